>>> design/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg: shared types for the TGA RLE pixel decoder
// Configuration bundle and the pixel token passed from front to back.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int unsigned BppW   = 3;
  localparam int unsigned WidthW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned PixW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_BPP   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RLE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH = 2'd2;

  localparam logic [BppW-1:0]   BPP_RESET   = 3'd3;
  localparam logic              RLE_RESET   = 1'b1;
  localparam logic [WidthW-1:0] WIDTH_RESET = 16'd256;

  localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;

  // What kind of pixel a token carries.
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,  // no packet structure
    KIND_RUN   = 2'd1,  // run packet pixel
    KIND_RAW   = 2'd2   // raw packet pixel
  } pix_kind_e;

  typedef struct packed {
    logic [BppW-1:0]   bpp;
    logic              rle;
    logic [WidthW-1:0] line_width;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0]   value;
    pix_kind_e         kind;
    logic [CountW-1:0] count;  // run length for a run pixel
    logic              last;   // last pixel of a raw packet
  } pix_tok_t;

endpackage

>>> design/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front: packet parser and pixel assembler
// Consumes one byte per word, tracks packet headers and pixel bytes, and
// emits one token per completed pixel.
// ----------------------------------------------------------------------------
module trd_front import trd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     fire_i,
  input  logic [7:0] byte_i,
  output logic     push_o,
  output pix_tok_t tok_o
);

  logic              expect_q, expect_d;
  logic              run_q, run_d;
  logic [7:0]        rem_q, rem_d;
  logic [1:0]        bip_q, bip_d;
  logic [23:0]       asm_q, asm_d;

  logic [BppW-1:0]   bpp_eff;
  logic [1:0]        bpp_m1;
  logic [PixW-1:0]   mask;
  logic [PixW-1:0]   value;
  logic [7:0]        rem_eff;
  logic [7:0]        rem_after;

  always_comb begin
    if (cfg_i.bpp == 3'd0) begin
      bpp_eff = 3'd1;
    end else if (cfg_i.bpp > 3'd4) begin
      bpp_eff = 3'd4;
    end else begin
      bpp_eff = cfg_i.bpp;
    end
  end

  assign bpp_m1 = 2'(bpp_eff - 3'd1);

  always_comb begin
    case (bpp_m1)
      2'd0:    mask = 32'h0000_00ff;
      2'd1:    mask = 32'h0000_ffff;
      2'd2:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign value     = ({8'd0, asm_q} | ({24'd0, byte_i} << {bpp_m1, 3'b000})) & mask;
  assign rem_eff   = (rem_q == 8'd0) ? 8'd1 : rem_q;
  assign rem_after = rem_eff - 8'd1;

  always_comb begin
    expect_d    = expect_q;
    run_d       = run_q;
    rem_d       = rem_q;
    bip_d       = bip_q;
    asm_d       = asm_q;
    push_o      = 1'b0;
    tok_o.value = value;
    tok_o.kind  = KIND_PLAIN;
    tok_o.count = rem_eff;
    tok_o.last  = (rem_after == 8'd0);
    if (fire_i) begin
      if (cfg_i.rle && expect_q) begin
        rem_d    = (byte_i & HDR_COUNT_MASK) + 8'd1;
        run_d    = byte_i[7];
        expect_d = 1'b0;
        bip_d    = 2'd0;
        asm_d    = 24'd0;
      end else if (({1'b0, bip_q} + 3'd1) < bpp_eff) begin
        asm_d = asm_q | ({16'd0, byte_i} << {bip_q, 3'b000});
        bip_d = bip_q + 2'd1;
      end else begin
        bip_d  = 2'd0;
        asm_d  = 24'd0;
        push_o = 1'b1;
        if (!cfg_i.rle) begin
          tok_o.kind = KIND_PLAIN;
        end else if (run_q) begin
          tok_o.kind = KIND_RUN;
          rem_d      = 8'd0;
          expect_d   = 1'b1;
        end else begin
          tok_o.kind = KIND_RAW;
          rem_d      = rem_after;
          if (rem_after == 8'd0) begin
            expect_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 1'b1;
      run_q    <= 1'b0;
      rem_q    <= 8'd0;
      bip_q    <= 2'd0;
      asm_q    <= 24'd0;
    end else begin
      expect_q <= expect_d;
      run_q    <= run_d;
      rem_q    <= rem_d;
      bip_q    <= bip_d;
      asm_q    <= asm_d;
    end
  end

endmodule

>>> design/trd_fifo.sv
// ----------------------------------------------------------------------------
// trd_fifo: small token queue between parser and line counter
// Register-based circular buffer with a fill count.
// ----------------------------------------------------------------------------
module trd_fifo import trd_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_tok_t wdata_i,
  input  logic     pop_i,
  output pix_tok_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pix_tok_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back: scan-line counter and output register
// Clips each pixel token against the line end and drives the result word.
// ----------------------------------------------------------------------------
module trd_back import trd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WidthW-1:0] line_width_i,
  input  logic              tok_valid_i,
  input  pix_tok_t          tok_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PixW-1:0]   out_value_o,
  output logic [CountW-1:0] out_count_o,
  output logic              out_lend_o,
  output logic              out_ovr_o
);

  logic [WidthW-1:0] pil_q, pil_d;
  logic              ov_q, ov_d;
  logic [PixW-1:0]   val_q;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              lend_q, lend_d;
  logic              ovr_q, ovr_d;

  logic [WidthW-1:0] w;
  logic              past_end;
  logic [WidthW-1:0] p;
  logic [WidthW:0]   p_inc;
  logic [WidthW-1:0] avail;
  logic              run_ovr;
  logic [CountW-1:0] run_cnt;
  logic [WidthW:0]   run_sum;
  logic              emit;

  assign w        = (line_width_i == '0) ? WidthW'(1) : line_width_i;
  assign past_end = (pil_q >= w);
  assign p        = past_end ? '0 : pil_q;
  assign p_inc    = {1'b0, p} + (WidthW + 1)'(1);
  assign avail    = w - p;
  assign run_ovr  = {{(WidthW - CountW){1'b0}}, tok_i.count} > avail;
  assign run_cnt  = run_ovr ? avail[CountW-1:0] : tok_i.count;
  assign run_sum  = {1'b0, p} + {{(WidthW + 1 - CountW){1'b0}}, run_cnt};

  // The output register can take a new word when empty or when drained now.
  assign pop_o = tok_valid_i && (!ov_q || out_ready_i);

  always_comb begin
    pil_d  = pil_q;
    cnt_d  = 8'd1;
    lend_d = 1'b0;
    ovr_d  = 1'b0;
    emit   = 1'b1;
    case (tok_i.kind)
      KIND_RUN: begin
        cnt_d  = run_cnt;
        lend_d = (run_sum == {1'b0, w});
        ovr_d  = run_ovr;
        pil_d  = lend_d ? '0 : run_sum[WidthW-1:0];
      end
      KIND_RAW: begin
        if (past_end) begin
          // Pixels past a clipped line end are swallowed until the packet ends.
          emit = 1'b0;
          if (tok_i.last) begin
            pil_d = '0;
          end
        end else begin
          lend_d = (p_inc == {1'b0, w});
          ovr_d  = lend_d && !tok_i.last;
          pil_d  = (lend_d && tok_i.last) ? '0 : p_inc[WidthW-1:0];
        end
      end
      default: begin
        lend_d = (p_inc == {1'b0, w});
        pil_d  = lend_d ? '0 : p_inc[WidthW-1:0];
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (pop_o) begin
      ov_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pil_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      ov_q <= ov_d;
      if (pop_o) begin
        pil_q <= pil_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      val_q  <= tok_i.value;
      cnt_q  <= cnt_d;
      lend_q <= lend_d;
      ovr_q  <= ovr_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_value_o = val_q;
  assign out_count_o = cnt_q;
  assign out_lend_o  = lend_q;
  assign out_ovr_o   = ovr_q;

endmodule

>>> design/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: Targa image-data RLE decoder
// Turns the image-data byte stream into pixel values with repeat counts.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one byte of image data per word (packet headers
//   and pixel bytes alike). The master channel gives one word per decoded
//   pixel or run: value, repeat count and overrun flag in tdata, and the
//   scan-line end on tlast.
//   Configuration (pixel size, RLE on/off, line width) is written through the
//   cfg port; the user must keep the stream idle while writing it, which the block does not enforce.
//   Throughput is one byte per cycle while the token queue is not full. After
//   the byte that completes its pixel, a result word is registered first in
//   the token queue, then in the line counter's output register.
//   When the receiver stalls, the output register holds its word and the
//   token queue fills; tready drops once the queue is full, and bytes that
//   only carry headers or partial pixels wait with it.
//   Reset clears the parser to expect a header, empties the queue, restarts
//   the line count and loads the default configuration (3 bytes per pixel,
//   RLE on, 256 pixels per line).
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder import trd_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [31:0] pixel_value, [39:32] repeat_count,
                                              // [40] overrun, [47:41] zero
  output logic                m_axis_tlast,   // line_end
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  logic              fire;
  logic              push;
  pix_tok_t          tok_in;
  pix_tok_t          tok_out;
  logic              full;
  logic              empty;
  logic              pop;
  logic [PixW-1:0]   out_value;
  logic [CountW-1:0] out_count;
  logic              out_ovr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bpp        <= BPP_RESET;
      cfg_q.rle        <= RLE_RESET;
      cfg_q.line_width <= WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:   cfg_q.bpp        <= cfg_data_i[BppW-1:0];
        CFG_RLE:   cfg_q.rle        <= cfg_data_i[0];
        CFG_WIDTH: cfg_q.line_width <= cfg_data_i[WidthW-1:0];
        default:   ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign fire          = s_axis_tvalid && s_axis_tready;

  trd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .push_o (push),
    .tok_o  (tok_in)
  );

  trd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (tok_in),
    .pop_i   (pop),
    .rdata_o (tok_out),
    .full_o  (full),
    .empty_o (empty)
  );

  trd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (cfg_q.line_width),
    .tok_valid_i  (!empty),
    .tok_i        (tok_out),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_count_o  (out_count),
    .out_lend_o   (m_axis_tlast),
    .out_ovr_o    (out_ovr)
  );

  assign m_axis_tdata = {7'd0, out_ovr, out_count, out_value};

endmodule

>>> design/trd_checker.sv
// ----------------------------------------------------------------------------
// trd_checker: port-level checks for the TGA RLE pixel decoder
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module trd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [47:0]         m_axis_tdata,
  input logic                m_axis_tlast
);

  // A stalled word stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // A stalled word keeps its contents.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // Every word stands for at least one pixel and at most one full packet.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[39:32] != 8'd0 && m_axis_tdata[39:32] <= 8'd128)
    else $error("repeat count out of range");

  // A clipped packet always stops at the line end.
  a_ovr_at_lend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tlast)
    else $error("overrun without line end");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[47:41] == 7'd0)
    else $error("nonzero padding in result word");

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (.*);
